// ----- rtl/core/ptc_pkg.sv -----
// Shared constants and types of the pattern table with hit counts.
package ptc_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int KEY_BITS    = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int OCC_W       = $clog2(TABLE_DEPTH + 1);
    localparam int COUNT_W     = 16;
    localparam int TARGET_W    = 16;
    localparam int SLOT_W      = 7;
    localparam int TALLY_W     = 7;

    localparam logic [COUNT_W-1:0]  COUNT_MAX     = '1;
    localparam logic [TARGET_W-1:0] TARGET_RESET  = TARGET_W'(10);
    localparam logic [OCC_W-1:0]    OCC_FULL      = OCC_W'(TABLE_DEPTH);

    typedef struct packed {
        logic                rd_en;
        logic [IDX_W-1:0]    rd_addr;
        logic                wr_en;
        logic                wr_key_en;
        logic [IDX_W-1:0]    wr_addr;
        logic [KEY_BITS-1:0] wr_key;
        logic [COUNT_W-1:0]  wr_count;
    } mem_req_t;

    typedef struct packed {
        logic               valid;
        logic [SLOT_W-1:0]  slot_number;
        logic               is_new;
        logic [COUNT_W-1:0] hit_count;
        logic               table_overflow;
        logic [TALLY_W-1:0] below_target_tally;
        logic               all_filled;
    } result_t;

endpackage

// ----- rtl/core/ptc_store.sv -----
// Key and count memories of the pattern table, one write and one registered read per cycle.
module ptc_store
    import ptc_pkg::*;
(
    input  logic                clk,
    input  mem_req_t            mem_req,
    output logic [KEY_BITS-1:0] rd_key,
    output logic [COUNT_W-1:0]  rd_count
);

    logic [KEY_BITS-1:0] key_mem   [TABLE_DEPTH];
    logic [COUNT_W-1:0]  count_mem [TABLE_DEPTH];
    logic [KEY_BITS-1:0] rd_key_reg;
    logic [COUNT_W-1:0]  rd_count_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.wr_en)
        begin
            count_mem[mem_req.wr_addr] <= mem_req.wr_count;
            if (mem_req.wr_key_en)
            begin
                key_mem[mem_req.wr_addr] <= mem_req.wr_key;
            end
        end
        if (mem_req.rd_en)
        begin
            rd_key_reg   <= key_mem[mem_req.rd_addr];
            rd_count_reg <= count_mem[mem_req.rd_addr];
        end
    end

    assign rd_key   = rd_key_reg;
    assign rd_count = rd_count_reg;

endmodule

// ----- rtl/core/ptc_engine.sv -----
// Search, tally and read-modify-write sequencer of the pattern table.
module ptc_engine
    import ptc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  logic [KEY_BITS-1:0] item_key,
    output logic                item_ready,
    input  logic                cfg_wr_en,
    input  logic [TARGET_W-1:0] cfg_wr_data,
    output mem_req_t            mem_req,
    input  logic [KEY_BITS-1:0] rd_key,
    input  logic [COUNT_W-1:0]  rd_count,
    input  logic                res_ready,
    output result_t             res
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t              state_reg;
    logic [TARGET_W-1:0] target_reg;
    logic [OCC_W-1:0]    occ_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic                issue_reg;
    logic [IDX_W-1:0]    rd_idx_reg;
    logic                chk_valid_reg;
    logic [IDX_W-1:0]    chk_idx_reg;
    logic                found_reg;
    logic [IDX_W-1:0]    hit_idx_reg;
    logic [COUNT_W-1:0]  hit_cnt_reg;
    logic [TALLY_W-1:0]  tally_reg;

    logic [IDX_W-1:0]    last_idx;
    logic                room;
    logic [COUNT_W-1:0]  inc_cnt;
    logic                under_old;
    logic                under_new;
    logic                under_one;
    logic [TALLY_W-1:0]  tally_fin;
    logic [OCC_W-1:0]    occ_fin;
    logic                finish_go;

    assign last_idx  = IDX_W'(occ_reg - OCC_W'(1));
    assign room      = (occ_reg < OCC_FULL);
    assign inc_cnt   = (hit_cnt_reg == COUNT_MAX) ? hit_cnt_reg : hit_cnt_reg + COUNT_W'(1);
    assign under_old = (hit_cnt_reg < target_reg);
    assign under_new = (inc_cnt < target_reg);
    assign under_one = (target_reg > TARGET_W'(1));
    assign finish_go = (state_reg == ST_FINISH) && res_ready;

    always_comb
    begin
        tally_fin = tally_reg;
        occ_fin   = occ_reg;
        if (found_reg)
        begin
            tally_fin = tally_reg - TALLY_W'(under_old) + TALLY_W'(under_new);
        end
        else if (room)
        begin
            tally_fin = tally_reg + TALLY_W'(under_one);
            occ_fin   = occ_reg + OCC_W'(1);
        end
    end

    always_comb
    begin
        mem_req.rd_en     = (state_reg == ST_SCAN) && issue_reg;
        mem_req.rd_addr   = rd_idx_reg;
        mem_req.wr_en     = finish_go && (found_reg || room);
        mem_req.wr_key_en = !found_reg;
        mem_req.wr_addr   = found_reg ? hit_idx_reg : IDX_W'(occ_reg);
        mem_req.wr_key    = key_reg;
        mem_req.wr_count  = found_reg ? inc_cnt : COUNT_W'(1);
    end

    always_comb
    begin
        res.valid              = finish_go;
        res.is_new             = !found_reg && room;
        res.table_overflow     = !found_reg && !room;
        res.slot_number        = '0;
        res.hit_count          = '0;
        if (found_reg)
        begin
            res.slot_number = SLOT_W'(hit_idx_reg) + SLOT_W'(1);
            res.hit_count   = inc_cnt;
        end
        else if (room)
        begin
            res.slot_number = SLOT_W'(occ_fin);
            res.hit_count   = COUNT_W'(1);
        end
        res.below_target_tally = tally_fin;
        res.all_filled         = (occ_fin != '0) && (tally_fin == '0);
    end

    assign item_ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            target_reg    <= TARGET_RESET;
            occ_reg       <= '0;
            issue_reg     <= 1'b0;
            chk_valid_reg <= 1'b0;
            rd_idx_reg    <= '0;
            chk_idx_reg   <= '0;
            found_reg     <= 1'b0;
            hit_idx_reg   <= '0;
            hit_cnt_reg   <= '0;
            tally_reg     <= '0;
            key_reg       <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                target_reg <= cfg_wr_data;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    chk_valid_reg <= 1'b0;
                    if (item_valid)
                    begin
                        key_reg     <= item_key;
                        found_reg   <= 1'b0;
                        tally_reg   <= '0;
                        rd_idx_reg  <= '0;
                        issue_reg   <= (occ_reg != '0);
                        state_reg   <= (occ_reg != '0) ? ST_SCAN : ST_FINISH;
                    end
                end
                ST_SCAN:
                begin
                    chk_valid_reg <= issue_reg;
                    chk_idx_reg   <= rd_idx_reg;
                    if (issue_reg)
                    begin
                        if (rd_idx_reg == last_idx)
                        begin
                            issue_reg <= 1'b0;
                        end
                        else
                        begin
                            rd_idx_reg <= rd_idx_reg + IDX_W'(1);
                        end
                    end
                    if (chk_valid_reg)
                    begin
                        if (rd_key == key_reg)
                        begin
                            found_reg   <= 1'b1;
                            hit_idx_reg <= chk_idx_reg;
                            hit_cnt_reg <= rd_count;
                        end
                        if (rd_count < target_reg)
                        begin
                            tally_reg <= tally_reg + TALLY_W'(1);
                        end
                        if (chk_idx_reg == last_idx)
                        begin
                            state_reg <= ST_FINISH;
                        end
                    end
                end
                ST_FINISH:
                begin
                    chk_valid_reg <= 1'b0;
                    if (res_ready)
                    begin
                        occ_reg   <= occ_fin;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_req.rd_en && mem_req.wr_en))
        else $error("memory read and write in the same cycle");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_FULL)
        else $error("occupancy beyond table depth");

    a_tally_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (OCC_W'(res.below_target_tally) <= occ_fin))
        else $error("tally exceeds occupancy");

    a_check_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        chk_valid_reg |-> (state_reg == ST_SCAN))
        else $error("read data checked outside the scan");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.table_overflow) |-> (occ_reg == OCC_FULL) && !res.is_new)
        else $error("overflow flagged on a table with room");

endmodule

// ----- rtl/core/pattern_table_with_hit_counts.sv -----
// Top level of the pattern table with hit counts: engine, memories and output register.
//
// Channel  Dir  Handshake          Contents
// s_axis   in   tvalid/tready      tdata: pattern_key
// m_axis   out  tvalid/tready      tdata: slot, count, tally, all_filled; tuser: flags
// cfg      in   cfg_wr_en          cfg_wr_data: population_target
//
// A new word is taken only after the last one is finished; the search makes one memory read per
// stored entry, and none when the table is empty.
// Its result reaches the output register as the engine returns to idle, ready for the next word.
// Reset clears occupancy, so the count memory needs no clearing pass.
// The finished result waits in an output register; a new word is taken meanwhile.
// A stalled output holds the engine in its final step until the register frees.
module pattern_table_with_hit_counts
    import ptc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [31:0]         s_axis_tdata,   // [31:0] pattern_key
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [31:0]         m_axis_tdata,   // [6:0] slot_number, [22:7] hit_count,
                                                // [29:23] below_target_tally, [30] all_filled
    output logic [1:0]          m_axis_tuser,   // [0] is_new, [1] table_overflow
    input  logic                cfg_wr_en,
    input  logic [TARGET_W-1:0] cfg_wr_data
);

    mem_req_t            mem_req;
    logic [KEY_BITS-1:0] rd_key;
    logic [COUNT_W-1:0]  rd_count;
    result_t             res;
    logic                res_ready;
    logic                out_valid_reg;
    logic [31:0]         out_data_reg;
    logic [1:0]          out_user_reg;

    assign res_ready = !out_valid_reg || m_axis_tready;

    ptc_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (s_axis_tvalid),
        .item_key    (s_axis_tdata[KEY_BITS-1:0]),
        .item_ready  (s_axis_tready),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .mem_req     (mem_req),
        .rd_key      (rd_key),
        .rd_count    (rd_count),
        .res_ready   (res_ready),
        .res         (res)
    );

    ptc_store u_store (
        .clk      (clk),
        .mem_req  (mem_req),
        .rd_key   (rd_key),
        .rd_count (rd_count)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            out_data_reg <= {1'b0, res.all_filled, res.below_target_tally,
                             res.hit_count, res.slot_number};
            out_user_reg <= {res.table_overflow, res.is_new};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule
